[rtl/core/tgard_pkg.sv]
// Shared types and constants for the TGA RLE pixel decoder.
// No dependencies; imported by every module of the decoder.
package tgard_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOTAL = 2'd2;

    localparam int          HDR_RUN_BIT  = 7;
    localparam logic [6:0]  HDR_COUNT_MASK = 7'h7f;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

    // pixel handed from the front end to the output stage
    typedef struct packed {
        logic       last;
        logic [7:0] rep;
        logic       alpha_flag;
        logic [7:0] final_byte;
        logic [7:0] red_raw;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_entry_t;

    // output tdata: red, green, blue, alpha, repeat from the lowest bit up
    typedef struct packed {
        logic [7:0] repeat_res;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_out_t;

endpackage

[rtl/core/tgard_front.sv]
// Front end: configuration registers, packet header parse, byte assembly,
// run clamp and pixel count. Depends on tgard_pkg.
module tgard_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [tgard_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tgard_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          byte_accept,
    input  logic [7:0]                    byte_data,
    output logic                          push,
    output tgard_pkg::pix_entry_t         push_entry
);
    import tgard_pkg::*;

    logic        rle_mode_reg, rle_mode_next;
    logic        has_alpha_reg, has_alpha_next;
    logic [31:0] done_reg, done_next;
    logic [31:0] remaining_reg, remaining_next;
    logic        finished_reg, finished_next;
    logic [1:0]  phase_reg, phase_next;
    logic        expect_hdr_reg, expect_hdr_next;
    logic        run_reg, run_next;
    logic [7:0]  left_reg, left_next;
    logic [23:0] pix_reg, pix_next;

    logic [1:0]  last_idx;
    logic [32:0] total_diff;
    logic [7:0]  rep_raw;
    logic [7:0]  rep;
    logic [7:0]  left_dec;
    logic        clamp;

    assign last_idx   = has_alpha_reg ? 2'd3 : 2'd2;
    assign total_diff = {1'b0, cfg_data} - {1'b0, done_reg};
    assign rep_raw    = (left_reg == 8'd0) ? 8'd1 : left_reg;
    assign clamp      = (remaining_reg[31:8] == 24'd0) && (remaining_reg[7:0] < rep_raw);
    assign left_dec   = (left_reg != 8'd0) ? left_reg - 8'd1 : 8'd0;

    always_comb begin
        rle_mode_next   = rle_mode_reg;
        has_alpha_next  = has_alpha_reg;
        done_next       = done_reg;
        remaining_next  = remaining_reg;
        finished_next   = finished_reg;
        phase_next      = phase_reg;
        expect_hdr_next = expect_hdr_reg;
        run_next        = run_reg;
        left_next       = left_reg;
        pix_next        = pix_reg;
        rep             = 8'd1;
        push            = 1'b0;

        if (byte_accept && !finished_reg) begin
            if (rle_mode_reg && expect_hdr_reg) begin
                run_next        = byte_data[HDR_RUN_BIT];
                left_next       = {1'b0, byte_data[6:0] & HDR_COUNT_MASK} + 8'd1;
                expect_hdr_next = 1'b0;
                phase_next      = 2'd0;
                pix_next        = '0;
            end else if (phase_reg < last_idx) begin
                unique case (phase_reg)
                    2'd0:    pix_next[7:0]   = byte_data;
                    2'd1:    pix_next[15:8]  = byte_data;
                    default: pix_next[23:16] = byte_data;
                endcase
                phase_next = phase_reg + 2'd1;
            end else begin
                push       = 1'b1;
                phase_next = 2'd0;
                pix_next   = '0;
                if (rle_mode_reg) begin
                    if (run_reg) begin
                        rep             = clamp ? remaining_reg[7:0] : rep_raw;
                        left_next       = 8'd0;
                        expect_hdr_next = 1'b1;
                    end else begin
                        left_next = left_dec;
                        if (left_dec == 8'd0) begin
                            expect_hdr_next = 1'b1;
                        end
                    end
                end
                done_next      = done_reg + {24'd0, rep};
                remaining_next = remaining_reg - {24'd0, rep};
                finished_next  = (remaining_reg == {24'd0, rep});
            end
        end

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_RLE_MODE:  rle_mode_next  = cfg_data[0];
                CFG_HAS_ALPHA: has_alpha_next = cfg_data[0];
                CFG_PIXEL_TOTAL: begin
                    remaining_next = total_diff[31:0];
                    finished_next  = total_diff[32] || (total_diff[31:0] == 32'd0);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        push_entry.last       = finished_next;
        push_entry.rep        = rep;
        push_entry.alpha_flag = has_alpha_reg;
        push_entry.final_byte = byte_data;
        push_entry.red_raw    = pix_reg[23:16];
        push_entry.green      = pix_reg[15:8];
        push_entry.blue       = pix_reg[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rle_mode_reg   <= 1'b0;
            has_alpha_reg  <= 1'b0;
            done_reg       <= 32'd0;
            remaining_reg  <= 32'd1;
            finished_reg   <= 1'b0;
            phase_reg      <= 2'd0;
            expect_hdr_reg <= 1'b1;
            run_reg        <= 1'b0;
            left_reg       <= 8'd0;
            pix_reg        <= 24'd0;
        end else begin
            rle_mode_reg   <= rle_mode_next;
            has_alpha_reg  <= has_alpha_next;
            done_reg       <= done_next;
            remaining_reg  <= remaining_next;
            finished_reg   <= finished_next;
            phase_reg      <= phase_next;
            expect_hdr_reg <= expect_hdr_next;
            run_reg        <= run_next;
            left_reg       <= left_next;
            pix_reg        <= pix_next;
        end
    end

endmodule

[rtl/core/tgard_queue.sv]
// Small pixel queue between front end and output stage.
// Depends on tgard_pkg for the entry type.
module tgard_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  tgard_pkg::pix_entry_t push_entry,
    output logic                  not_full,
    output logic                  not_empty,
    input  logic                  pop,
    output tgard_pkg::pix_entry_t pop_entry
);
    import tgard_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pix_entry_t       entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_entry = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/tgard_back.sv]
// Output stage: BGR(A) to RGB(A) reorder, alpha fill and result register.
// Depends on tgard_pkg.
module tgard_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  tgard_pkg::pix_entry_t q_entry,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output tgard_pkg::pix_out_t   m_tdata,
    output logic                  m_tlast
);
    import tgard_pkg::*;

    logic     valid_reg, valid_next;
    pix_out_t data_reg, data_next;
    logic     last_reg, last_next;

    assign q_pop = q_valid && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (q_pop) begin
            valid_next           = 1'b1;
            data_next.red        = q_entry.alpha_flag ? q_entry.red_raw : q_entry.final_byte;
            data_next.green      = q_entry.green;
            data_next.blue       = q_entry.blue;
            data_next.alpha      = q_entry.alpha_flag ? q_entry.final_byte : ALPHA_OPAQUE;
            data_next.repeat_res = q_entry.rep;
            last_next            = q_entry.last;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

[rtl/core/tga_rle_pixel_decoder.sv]
// TGA truecolor payload decoder: one payload byte per cycle in, one pixel
// with a repeat count out per completed pixel or run. Top level; uses
// tgard_pkg, tgard_front, tgard_queue and tgard_back.
//
// Bytes are taken at one per cycle; s_tready falls only when the pixel queue
// (QUEUE_DEPTH entries) is full because m_tready is held low. Pixels pass
// the queue and the output register. Runs are clamped so the repeat counts
// since reset sum to pixel_total; bytes after the last pixel are taken and
// dropped. Configuration (cfg_index 0 rle_mode, 1 has_alpha, 2 pixel_total)
// is always ready and should be written between images.
module tga_rle_pixel_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // red, green, blue, alpha, repeat_res
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [tgard_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tgard_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tgard_pkg::*;

    logic       push, q_not_full, q_not_empty, q_pop;
    pix_entry_t push_entry, pop_entry;
    pix_out_t   out_data;

    assign cfg_ready = 1'b1;
    assign s_tready  = q_not_full;

    tgard_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .byte_accept (s_tvalid && s_tready),
        .byte_data   (s_tdata),
        .push        (push),
        .push_entry  (push_entry)
    );

    tgard_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .not_full   (q_not_full),
        .not_empty  (q_not_empty),
        .pop        (q_pop),
        .pop_entry  (pop_entry)
    );

    tgard_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (out_data),
        .m_tlast  (m_tlast)
    );

    assign m_tdata = out_data;

endmodule

[tb/tgard_pixel_checker.sv]
`timescale 1ns / 100ps
// Pixel checker for the TGA RLE pixel decoder: snoops the byte, pixel and register
// channels, predicts every decoded pixel and compares it with what comes out.
// Depends on tgard_pkg for register indexes, header layout and the pixel word.
module tgard_pixel_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // data_byte
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [39:0]                        m_tdata,   // red, green, blue, alpha, repeat_res
    input  logic                               m_tlast,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [tgard_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tgard_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                 fail_count,
    output int                                 pixels_pending
);
    import tgard_pkg::*;

    typedef struct packed {
        logic     last;
        pix_out_t px;
    } pixel_exp_t;

    logic        cfg_rle   = 1'b0;
    logic        cfg_alpha = 1'b0;
    logic [31:0] cfg_total = 32'd1;

    logic [2:0]  phase       = 3'd0;
    logic        want_header = 1'b1;
    logic        in_run      = 1'b0;
    logic [7:0]  pkt_left    = 8'd0;
    logic [23:0] held_bytes  = 24'd0;
    logic [31:0] done_cnt    = 32'd0;

    pixel_exp_t  pixel_q[$];
    int          errs = 0;
    int          pend = 0;

    assign fail_count     = errs;
    assign pixels_pending = pend;

    task automatic flag_field(input string name, input logic [7:0] want,
                              input logic [7:0] seen);
        if (seen !== want) begin
            errs++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
        end
    endtask

    task automatic check_pixel();
        pix_out_t   got;
        pixel_exp_t want;
        got = m_tdata;
        if (pixel_q.size() == 0) begin
            errs++;
            $display("%0t: unexpected pixel, expected none, got %h last %b",
                     $time, m_tdata, m_tlast);
            return;
        end
        want = pixel_q.pop_front();
        flag_field("red",    want.px.red,        got.red);
        flag_field("green",  want.px.green,      got.green);
        flag_field("blue",   want.px.blue,       got.blue);
        flag_field("alpha",  want.px.alpha,      got.alpha);
        flag_field("repeat", want.px.repeat_res, got.repeat_res);
        flag_field("last",   {7'd0, want.last},  {7'd0, m_tlast});
    endtask

    task automatic decode_byte(input logic [7:0] d);
        logic [2:0]  last_idx;
        logic [31:0] missing;
        logic [31:0] rep;
        pixel_exp_t  pix;
        last_idx = cfg_alpha ? 3'd3 : 3'd2;
        if (done_cnt >= cfg_total)
            return;
        if (cfg_rle && want_header) begin
            in_run      = d[HDR_RUN_BIT];
            pkt_left    = {1'b0, d[6:0] & HDR_COUNT_MASK} + 8'd1;
            want_header = 1'b0;
            phase       = 3'd0;
            held_bytes  = 24'd0;
            return;
        end
        if (phase < last_idx) begin
            held_bytes = held_bytes | (24'(d) << (8 * phase[1:0]));
            phase      = phase + 3'd1;
            return;
        end
        // final byte of the pixel
        pix.px.blue  = held_bytes[7:0];
        pix.px.green = held_bytes[15:8];
        if (cfg_alpha) begin
            pix.px.red   = held_bytes[23:16];
            pix.px.alpha = d;
        end else begin
            pix.px.red   = d;
            pix.px.alpha = ALPHA_OPAQUE;
        end
        phase      = 3'd0;
        held_bytes = 24'd0;
        rep = 32'd1;
        if (cfg_rle) begin
            if (in_run) begin
                missing = cfg_total - done_cnt;
                rep     = {24'd0, pkt_left};
                if (rep == 32'd0)
                    rep = 32'd1;
                if (rep > missing)
                    rep = missing;
                pkt_left    = 8'd0;
                want_header = 1'b1;
            end else begin
                if (pkt_left != 8'd0)
                    pkt_left = pkt_left - 8'd1;
                if (pkt_left == 8'd0)
                    want_header = 1'b1;
            end
        end
        done_cnt = done_cnt + rep;
        pix.px.repeat_res = rep[7:0];
        pix.last = (done_cnt == cfg_total);
        pixel_q.push_back(pix);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_rle     = 1'b0;
            cfg_alpha   = 1'b0;
            cfg_total   = 32'd1;
            phase       = 3'd0;
            want_header = 1'b1;
            in_run      = 1'b0;
            pkt_left    = 8'd0;
            held_bytes  = 24'd0;
            done_cnt    = 32'd0;
            pixel_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RLE_MODE:    cfg_rle   = cfg_data[0];
                    CFG_HAS_ALPHA:   cfg_alpha = cfg_data[0];
                    CFG_PIXEL_TOTAL: cfg_total = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_pixel();
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
        end
        pend = pixel_q.size();
    end

endmodule

[tb/tb_tga_rle_pixel_decoder.sv]
`timescale 1ns / 100ps
// Testbench top for tga_rle_pixel_decoder: drives payload byte streams, register
// writes and output back-pressure, and reports the verdict.
// Depends on tgard_pkg, the decoder RTL and tgard_pixel_checker.
module tb_tga_rle_pixel_decoder;
    import tgard_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BYTES = 1900;
    localparam int DRAIN_CYCLES = 8;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [39:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_RLE_MODE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int          fail_count;
    int          pixels_pending;
    int          cycle_cnt     = 0;
    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    int          payload_bytes = 0;
    int          lit_left      = 0;
    logic        hold_req      = 1'b0;
    logic        cur_alpha     = 1'b0;
    logic [31:0] done_pix      = 32'd0;

    tga_rle_pixel_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tgard_pixel_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pixels_pending (pixels_pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // pixel sink: random stalls, plus one long hold-off on request
    initial begin : pixel_sink
        int held;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_NONE: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            IDLE_SRC:  begin src_idle_pct = 59; snk_stall_pct = 0;  end
            IDLE_SNK:  begin src_idle_pct = 0;  snk_stall_pct = 59; end
            default:   begin src_idle_pct = 6;  snk_stall_pct = 6;  end
        endcase
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        payload_bytes++;
    endtask

    task automatic push_pixel();
        repeat (cur_alpha ? 4 : 3) push_byte(rand_byte());
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pixels_pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic open_image(input logic rle, input logic alpha, input logic [31:0] total);
        wait_drained();
        write_reg(CFG_RLE_MODE, {31'd0, rle});
        write_reg(CFG_HAS_ALPHA, {31'd0, alpha});
        write_reg(CFG_PIXEL_TOTAL, total);
        cfg_valid <= 1'b0;
        cur_alpha = alpha;
    endtask

    task automatic send_raw_image(input int npix);
        repeat (npix) push_pixel();
        done_pix += npix;
    endtask

    // well-formed packets; now and then a literal packet runs past the end and
    // its remaining pixels open the next run-length image
    task automatic send_rle_image(input int npix);
        int remaining;
        int cnt;
        int k;
        remaining = npix;
        k = (lit_left < remaining) ? lit_left : remaining;
        repeat (k) push_pixel();
        lit_left  -= k;
        remaining -= k;
        while (remaining > 0) begin
            cnt = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 127);
            if ($urandom_range(0, 1) != 0) begin
                push_byte({1'b1, 7'(cnt)});
                push_pixel();
                remaining -= (cnt + 1 < remaining) ? cnt + 1 : remaining;
            end else begin
                if (cnt + 1 > remaining && $urandom_range(0, 9) != 0)
                    cnt = $urandom_range(0, remaining - 1);
                push_byte({1'b0, 7'(cnt)});
                k = (cnt + 1 < remaining) ? cnt + 1 : remaining;
                repeat (k) push_pixel();
                lit_left   = cnt + 1 - k;
                remaining -= k;
            end
        end
        done_pix += npix;
    endtask

    task automatic push_trailing(input int n);
        repeat (n) push_byte(rand_byte());
        payload_bytes -= n;
    endtask

    initial begin : stimulus
        int img;
        int n;
        logic alpha;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        set_idle(IDLE_NONE);

        // register defaults: raw, three bytes, one pixel; then a stray byte
        push_byte(8'h01);
        push_byte(8'h80);
        push_byte(8'hff);
        done_pix += 1;
        push_trailing(1);

        // zero pixel total: nothing is decoded
        wait_drained();
        write_reg(CFG_PIXEL_TOTAL, 32'd0);
        cfg_valid <= 1'b0;
        push_byte(8'h5a);

        // raw with alpha, all-zero pixel
        open_image(1'b0, 1'b1, done_pix + 1);
        repeat (4) push_byte(8'h00);
        done_pix += 1;

        // alpha dropped while three bytes of a pixel are held
        open_image(1'b0, 1'b1, done_pix + 1);
        push_byte(8'h11);
        push_byte(8'h22);
        push_byte(8'h33);
        wait_drained();
        write_reg(CFG_HAS_ALPHA, 32'd0);
        cfg_valid <= 1'b0;
        cur_alpha = 1'b0;
        push_byte(8'h44);
        done_pix += 1;

        // longest run, then a run clamped at the image end
        open_image(1'b1, 1'b0, done_pix + 130);
        push_byte({1'b1, 7'h7f});
        repeat (3) push_byte(8'hff);
        push_byte({1'b1, 7'h05});
        push_byte(8'h0f);
        push_byte(8'hf0);
        push_byte(8'h00);
        done_pix += 130;

        // single literal pixel
        open_image(1'b1, 1'b0, done_pix + 1);
        push_byte({1'b0, 7'h00});
        push_pixel();
        done_pix += 1;

        for (img = 0; payload_bytes < RANDOM_BYTES; img++) begin
            set_idle(idle_mode_e'(img % 4));
            alpha = 1'($urandom_range(0, 1));
            if (img == 3) begin
                // image that cannot complete: largest pixel total
                open_image(1'b0, alpha, 32'hffff_ffff);
                send_raw_image($urandom_range(2, 6));
            end else begin
                if (img == 1) begin
                    set_idle(IDLE_NONE);
                    open_image(1'b0, alpha, done_pix + 24);
                    hold_req = 1'b1;
                    send_raw_image(24);
                end else if ($urandom_range(0, 9) < 7) begin
                    n = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 40)
                                                    : $urandom_range(41, 300);
                    open_image(1'b1, alpha, done_pix + n);
                    send_rle_image(n);
                end else begin
                    n = $urandom_range(1, 10);
                    open_image(1'b0, alpha, done_pix + n);
                    send_raw_image(n);
                end
                if ($urandom_range(0, 4) == 0)
                    push_trailing($urandom_range(1, 4));
            end
        end

        set_idle(IDLE_NONE);
        wait_drained();
        repeat (20) @(negedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
